>>> sv/wdt_pkg.sv
`timescale 1ns / 1ps

package wdt_pkg;

  // Counter width (8 to 32); Load writes are truncated to it
  localparam int unsigned COUNT_WIDTH = 32;

  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned ADDR_WIDTH = 12;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [DATA_WIDTH-1:0]  word_t;
  typedef logic [ADDR_WIDTH-1:0]  addr_t;

  // Beat operation codes
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Register offsets
  localparam addr_t REG_LOAD    = 12'h000;
  localparam addr_t REG_VALUE   = 12'h004;
  localparam addr_t REG_CONTROL = 12'h008;
  localparam addr_t REG_INTCLR  = 12'h00C;
  localparam addr_t REG_RIS     = 12'h010;
  localparam addr_t REG_MIS     = 12'h014;
  localparam addr_t REG_LOCK    = 12'hC00;
  localparam addr_t REG_PID0    = 12'hFE0;
  localparam addr_t REG_PID1    = 12'hFE4;
  localparam addr_t REG_PID2    = 12'hFE8;
  localparam addr_t REG_PID3    = 12'hFEC;
  localparam addr_t REG_CID0    = 12'hFF0;
  localparam addr_t REG_CID1    = 12'hFF4;
  localparam addr_t REG_CID2    = 12'hFF8;
  localparam addr_t REG_CID3    = 12'hFFC;

  localparam word_t UNLOCK_WORD = 32'h1ACC_E551;

  // ID register contents
  localparam word_t PID0_VAL = 32'h0000_0005;
  localparam word_t PID1_VAL = 32'h0000_0018;
  localparam word_t PID2_VAL = 32'h0000_0014;
  localparam word_t PID3_VAL = 32'h0000_0000;
  localparam word_t CID0_VAL = 32'h0000_000D;
  localparam word_t CID1_VAL = 32'h0000_00F0;
  localparam word_t CID2_VAL = 32'h0000_0005;
  localparam word_t CID3_VAL = 32'h0000_00B1;

  // Control bit positions
  localparam int unsigned INT_EN_BIT = 0;
  localparam int unsigned RST_EN_BIT = 1;

endpackage

>>> sv/watchdog_timer_regs.sv
`timescale 1ns / 1ps

// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid / in_ready | operation, address, write_data
// out     | output    | out_valid/out_ready | read_data, irq, wdog_reset
//
// One beat per cycle while out is not stalled: a beat is decoded and applied to
// the registers in the cycle it is accepted, and its result lands in the single
// output register next edge.
// in_ready is high while the output register is empty or being drained, so
// a stall on out holds in; nothing else throttles the input.
// rst (synchronous) restores load/count to all ones and clears all flags.

module watchdog_timer_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          operation,
  input  wdt_pkg::addr_t      address,
  input  wdt_pkg::word_t      write_data,
  output logic                out_valid,
  input  logic                out_ready,
  output wdt_pkg::word_t      read_data,
  output logic                irq,
  output logic                wdog_reset
);
  import wdt_pkg::*;

  // Architectural state
  count_t     load_value;
  count_t     count_value;
  logic [1:0] control_bits;
  logic       raw_irq_flag;
  logic       lock_flag;
  logic       reset_flag;

  count_t     load_value_next;
  count_t     count_value_next;
  logic [1:0] control_bits_next;
  logic       raw_irq_flag_next;
  logic       lock_flag_next;
  logic       reset_flag_next;
  word_t      read_data_next;

  logic in_fire;
  op_t  op;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign op       = op_t'(operation);

  // Register read mux
  always_comb begin
    unique case (address)
      REG_LOAD:    read_data_next = DATA_WIDTH'(load_value);
      REG_VALUE:   read_data_next = DATA_WIDTH'(count_value);
      REG_CONTROL: read_data_next = DATA_WIDTH'(control_bits);
      REG_RIS:     read_data_next = DATA_WIDTH'(raw_irq_flag);
      REG_MIS:     read_data_next = DATA_WIDTH'(raw_irq_flag & control_bits[INT_EN_BIT]);
      REG_LOCK:    read_data_next = DATA_WIDTH'(lock_flag);
      REG_PID0:    read_data_next = PID0_VAL;
      REG_PID1:    read_data_next = PID1_VAL;
      REG_PID2:    read_data_next = PID2_VAL;
      REG_PID3:    read_data_next = PID3_VAL;
      REG_CID0:    read_data_next = CID0_VAL;
      REG_CID1:    read_data_next = CID1_VAL;
      REG_CID2:    read_data_next = CID2_VAL;
      REG_CID3:    read_data_next = CID3_VAL;
      default:     read_data_next = '0;
    endcase
    if (op != OP_READ) begin
      read_data_next = '0;
    end
  end

  // Next-state for tick and write beats
  always_comb begin
    load_value_next   = load_value;
    count_value_next  = count_value;
    control_bits_next = control_bits;
    raw_irq_flag_next = raw_irq_flag;
    lock_flag_next    = lock_flag;
    reset_flag_next   = reset_flag;
    unique case (op)
      OP_TICK: begin
        if (control_bits[INT_EN_BIT] && !reset_flag) begin
          if (count_value != '0) begin
            count_value_next = count_value - 1'b1;
          end else if (!raw_irq_flag) begin
            // first timeout: flag and reload
            raw_irq_flag_next = 1'b1;
            count_value_next  = load_value;
          end else if (control_bits[RST_EN_BIT]) begin
            reset_flag_next = 1'b1;
          end else begin
            count_value_next = load_value;
          end
        end
      end
      OP_WRITE: begin
        if (address == REG_LOCK) begin
          lock_flag_next = (write_data != UNLOCK_WORD);
        end else if (!lock_flag) begin
          if (address == REG_LOAD) begin
            load_value_next  = write_data[COUNT_WIDTH-1:0];
            count_value_next = write_data[COUNT_WIDTH-1:0];
          end else if (address == REG_CONTROL) begin
            control_bits_next = write_data[1:0];
            if (!control_bits[INT_EN_BIT] && write_data[INT_EN_BIT] && !reset_flag) begin
              count_value_next = load_value;
            end
          end else if (address == REG_INTCLR) begin
            raw_irq_flag_next = 1'b0;
            count_value_next  = load_value;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // State and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      load_value   <= '1;
      count_value  <= '1;
      control_bits <= '0;
      raw_irq_flag <= 1'b0;
      lock_flag    <= 1'b0;
      reset_flag   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (in_fire) begin
        load_value   <= load_value_next;
        count_value  <= count_value_next;
        control_bits <= control_bits_next;
        raw_irq_flag <= raw_irq_flag_next;
        lock_flag    <= lock_flag_next;
        reset_flag   <= reset_flag_next;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      read_data  <= read_data_next;
      irq        <= raw_irq_flag_next & control_bits_next[INT_EN_BIT];
      wdog_reset <= reset_flag_next;
    end
  end

  // Reset request is sticky until rst
  a_reset_sticky: assert property (@(posedge clk) disable iff (rst)
    reset_flag |=> reset_flag)
    else $error("reset_flag dropped without rst");

  // Ticks do not move the counter once reset is raised
  a_count_frozen: assert property (@(posedge clk) disable iff (rst)
    (reset_flag && in_fire && op == OP_TICK) |=> $stable(count_value))
    else $error("counter moved after reset raised");

  // Pending result reflects current state (state only moves with a new beat)
  a_levels_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (irq == (raw_irq_flag & control_bits[INT_EN_BIT]))
                  && (wdog_reset == reset_flag))
    else $error("output levels out of step with state");

  // Locked writes off the lock register change nothing
  a_locked_write: assert property (@(posedge clk) disable iff (rst)
    (in_fire && lock_flag && op == OP_WRITE && address != REG_LOCK)
      |=> $stable(load_value) && $stable(count_value) && $stable(control_bits)
          && $stable(raw_irq_flag))
    else $error("write took effect while locked");

  // A stalled result blocks the input
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input accepted over a stalled result");

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import wdt_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int MAIN_BEATS  = 1100;
  localparam int TAIL_BEATS  = 150;

  typedef struct packed {
    word_t rdata;
    logic  irq;
    logic  rst_req;
  } wdt_resp_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] operation;
  addr_t      address;
  word_t      write_data;
  logic       out_valid;
  logic       out_ready;
  word_t      read_data;
  logic       irq;
  logic       wdog_reset;

  // Predicted watchdog state
  count_t     wd_load;
  count_t     wd_count;
  logic [1:0] wd_ctrl;
  logic       wd_ris;
  logic       wd_locked;
  logic       wd_reset_req;

  wdt_resp_t  response_q[$];
  int         err_count   = 0;
  int         beats_sent  = 0;
  int         cycle_count = 0;
  bit         idle_on     = 1'b1;
  // Reset-enable stays off until the last phase: a raised reset request is sticky
  bit         resen_ok    = 1'b0;

  watchdog_timer_regs dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .address     (address),
    .write_data  (write_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .read_data   (read_data),
    .irq         (irq),
    .wdog_reset  (wdog_reset)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // Apply one beat to the predicted state and queue the response it gives
  function automatic void predict_response(logic [1:0] op, addr_t a, word_t d);
    wdt_resp_t r;
    r.rdata = '0;
    case (op_t'(op))
      OP_TICK: begin
        if (wd_ctrl[INT_EN_BIT] && !wd_reset_req) begin
          if (wd_count != '0) begin
            wd_count = wd_count - 1'b1;
          end else if (wd_ris) begin
            if (wd_ctrl[RST_EN_BIT]) wd_reset_req = 1'b1;
            else wd_count = wd_load;
          end else begin
            wd_ris   = 1'b1;
            wd_count = wd_load;
          end
        end
      end
      OP_READ: begin
        case (a)
          REG_LOAD:    r.rdata = word_t'(wd_load);
          REG_VALUE:   r.rdata = word_t'(wd_count);
          REG_CONTROL: r.rdata = word_t'(wd_ctrl);
          REG_RIS:     r.rdata = word_t'(wd_ris);
          REG_MIS:     r.rdata = word_t'(wd_ris & wd_ctrl[INT_EN_BIT]);
          REG_LOCK:    r.rdata = word_t'(wd_locked);
          REG_PID0:    r.rdata = PID0_VAL;
          REG_PID1:    r.rdata = PID1_VAL;
          REG_PID2:    r.rdata = PID2_VAL;
          REG_PID3:    r.rdata = PID3_VAL;
          REG_CID0:    r.rdata = CID0_VAL;
          REG_CID1:    r.rdata = CID1_VAL;
          REG_CID2:    r.rdata = CID2_VAL;
          REG_CID3:    r.rdata = CID3_VAL;
          default:     r.rdata = '0;
        endcase
      end
      OP_WRITE: begin
        if (a == REG_LOCK) begin
          wd_locked = (d != UNLOCK_WORD);
        end else if (!wd_locked) begin
          case (a)
            REG_LOAD: begin
              wd_load  = count_t'(d);
              wd_count = wd_load;
            end
            REG_CONTROL: begin
              // enable rising edge reloads, unless reset was already requested
              if (!wd_ctrl[INT_EN_BIT] && d[INT_EN_BIT] && !wd_reset_req) wd_count = wd_load;
              wd_ctrl = d[1:0];
            end
            REG_INTCLR: begin
              wd_ris   = 1'b0;
              wd_count = wd_load;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    r.irq     = wd_ris & wd_ctrl[INT_EN_BIT];
    r.rst_req = wd_reset_req;
    response_q.push_back(r);
  endfunction

  task automatic flag_mismatch(string what, word_t want, word_t got);
    err_count++;
    if (err_count <= 10) $display("mismatch %s: expected %h, got %h", what, want, got);
  endtask

  // Send one beat; the payload holds until accepted
  task automatic send_beat(logic [1:0] op, addr_t a, word_t d);
    if (op == OP_WRITE && a == REG_CONTROL && !resen_ok) d[RST_EN_BIT] = 1'b0;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    address    <= a;
    write_data <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_response(op, a, d);
    beats_sent++;
  endtask

  // Response checker
  always @(posedge clk) begin
    wdt_resp_t want;
    if (!rst && out_valid && out_ready) begin
      if (response_q.size() == 0) begin
        flag_mismatch("unexpected beat", '0, read_data);
      end else begin
        want = response_q.pop_front();
        if (read_data !== want.rdata) flag_mismatch("read_data", want.rdata, read_data);
        if (irq !== want.irq) flag_mismatch("irq", word_t'(want.irq), word_t'(irq));
        if (wdog_reset !== want.rst_req)
          flag_mismatch("wdog_reset", word_t'(want.rst_req), word_t'(wdog_reset));
      end
    end
  end

  // Output backpressure in short random bursts
  initial begin
    @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  function automatic addr_t pick_reg();
    case ($urandom_range(0, 14))
      0:       return REG_LOAD;
      1:       return REG_VALUE;
      2:       return REG_CONTROL;
      3:       return REG_INTCLR;
      4:       return REG_RIS;
      5:       return REG_MIS;
      6:       return REG_LOCK;
      7:       return REG_PID0;
      8:       return REG_PID1;
      9:       return REG_PID2;
      10:      return REG_PID3;
      11:      return REG_CID0;
      12:      return REG_CID1;
      13:      return REG_CID2;
      default: return REG_CID3;
    endcase
  endfunction

  task automatic test_reset_state();
    send_beat(OP_READ, REG_LOAD, '0);
    send_beat(OP_READ, REG_VALUE, '0);
    send_beat(OP_READ, REG_CONTROL, '0);
    send_beat(OP_READ, REG_INTCLR, '0);
    send_beat(OP_READ, REG_RIS, '0);
    send_beat(OP_READ, REG_MIS, '0);
    send_beat(OP_READ, REG_LOCK, '0);
  endtask

  task automatic test_id_space();
    send_beat(OP_READ, REG_PID0, '0);
    send_beat(OP_READ, REG_PID1, '0);
    send_beat(OP_READ, REG_PID2, '0);
    send_beat(OP_READ, REG_PID3, '0);
    send_beat(OP_READ, REG_CID0, '0);
    send_beat(OP_READ, REG_CID1, '0);
    send_beat(OP_READ, REG_CID2, '0);
    send_beat(OP_READ, REG_CID3, '0);
    // unused opcode does nothing
    send_beat(OP_NONE, REG_LOAD, 32'hFFFF_FFFF);
  endtask

  task automatic test_countdown_irq();
    // enable from all ones, one tick down
    send_beat(OP_WRITE, REG_CONTROL, 32'h1);
    send_beat(OP_TICK, '0, '0);
    send_beat(OP_READ, REG_VALUE, '0);
    // short period: first timeout raises the interrupt
    send_beat(OP_WRITE, REG_LOAD, 32'h1);
    send_beat(OP_TICK, '0, '0);
    send_beat(OP_TICK, '0, '0);
    send_beat(OP_READ, REG_MIS, '0);
    // read-only registers ignore writes; then clear the interrupt
    send_beat(OP_WRITE, REG_VALUE, '0);
    send_beat(OP_WRITE, REG_RIS, '0);
    send_beat(OP_WRITE, REG_INTCLR, 32'hFFFF_FFFF);
  endtask

  task automatic test_lock();
    send_beat(OP_WRITE, REG_LOCK, '0);
    send_beat(OP_WRITE, REG_LOAD, 32'hFFFF_FFFF);
    send_beat(OP_WRITE, REG_INTCLR, '0);
    send_beat(OP_READ, REG_LOCK, '0);
    send_beat(OP_WRITE, REG_LOCK, UNLOCK_WORD);
    send_beat(OP_WRITE, REG_LOAD, 32'hFFFF_FFFF);
  endtask

  // Set a mostly short period and control; tick amid reads, clears and writes
  task automatic run_timeout_sequence();
    word_t d;
    if ($urandom_range(0, 7) != 0) send_beat(OP_WRITE, REG_LOCK, UNLOCK_WORD);
    if ($urandom_range(0, 9) != 0) send_beat(OP_WRITE, REG_LOAD, $urandom_range(0, 6));
    else send_beat(OP_WRITE, REG_LOAD, $urandom);
    d = $urandom;
    d[INT_EN_BIT] = ($urandom_range(0, 4) != 0);
    send_beat(OP_WRITE, REG_CONTROL, d);
    repeat ($urandom_range(1, 24)) begin
      case ($urandom_range(0, 11))
        0, 1, 2, 3, 4, 5: send_beat(OP_TICK, addr_t'($urandom), $urandom);
        6, 7: send_beat(OP_READ, pick_reg(), $urandom);
        8: send_beat(OP_WRITE, REG_INTCLR, $urandom);
        9: send_beat(OP_WRITE, REG_CONTROL, $urandom);
        10: send_beat(OP_WRITE, REG_LOAD, $urandom_range(0, 4));
        default: begin
          if ($urandom_range(0, 1) == 0) send_beat(OP_WRITE, REG_LOCK, $urandom);
          else send_beat(OP_WRITE, REG_LOCK, UNLOCK_WORD);
        end
      endcase
    end
  endtask

  // Unstructured beats: any opcode, random or near-miss addresses
  task automatic run_noise();
    addr_t a;
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 1) == 0) a = addr_t'($urandom);
      else a = pick_reg() ^ (addr_t'(1) << $urandom_range(0, ADDR_WIDTH - 1));
      if ($urandom_range(0, 3) == 0) a = pick_reg();
      send_beat(2'($urandom_range(0, 3)), a, $urandom);
    end
  endtask

  task automatic run_random_traffic(int n_beats);
    int stop_at;
    stop_at = beats_sent + n_beats;
    while (beats_sent < stop_at) begin
      if ($urandom_range(0, 4) != 0) run_timeout_sequence();
      else run_noise();
    end
  endtask

  // Second timeout with reset enabled: reset request sticks, counter freezes
  task automatic test_reset_request();
    idle_on  = 1'b0;
    resen_ok = 1'b1;
    send_beat(OP_WRITE, REG_LOCK, UNLOCK_WORD);
    send_beat(OP_WRITE, REG_LOAD, '0);
    send_beat(OP_WRITE, REG_CONTROL, 32'hFFFF_FFFF);
    send_beat(OP_TICK, '0, '0);
    send_beat(OP_TICK, '0, '0);
    send_beat(OP_TICK, '0, '0);
    send_beat(OP_READ, REG_VALUE, '0);
    // re-enable after reset request must not reload
    send_beat(OP_WRITE, REG_CONTROL, '0);
    send_beat(OP_WRITE, REG_LOAD, 32'h5);
    send_beat(OP_WRITE, REG_CONTROL, 32'h3);
    send_beat(OP_WRITE, REG_INTCLR, '0);
    send_beat(OP_READ, REG_RIS, '0);
    run_random_traffic(TAIL_BEATS);
  endtask

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    operation  = OP_TICK;
    address    = '0;
    write_data = '0;
    out_ready  = 1'b0;
    wd_load      = '1;
    wd_count     = '1;
    wd_ctrl      = '0;
    wd_ris       = 1'b0;
    wd_locked    = 1'b0;
    wd_reset_req = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_id_space();
    test_countdown_irq();
    test_lock();
    run_random_traffic(MAIN_BEATS);
    test_reset_request();

    in_valid <= 1'b0;
    while (response_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (err_count == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule
